FILE: rtl/core/ptd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptd_pkg;

    // default table depth
    localparam int MAX_TASKS_DEF = 16;

    // operation codes
    localparam logic [1:0] OP_REG  = 2'd0;
    localparam logic [1:0] OP_ACT  = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // status codes
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    // command token handed from cell to cell
    typedef struct packed {
        logic        v;
        logic [1:0]  op;
        logic [7:0]  id;
        logic [31:0] per;
        logic [31:0] now;
        logic        flag;
    } t_tok;

    // dispatch event raised by the cell holding the token
    typedef struct packed {
        logic       v;
        logic [7:0] id;
    } t_evt;

endpackage

`default_nettype wire

FILE: rtl/core/ptd_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module ptd_cell (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_adv,
    input  ptd_pkg::t_tok i_tok,
    output ptd_pkg::t_tok o_tok,
    output ptd_pkg::t_evt o_evt
);
    import ptd_pkg::*;

    logic        r_occ;
    logic        r_ready;
    logic [7:0]  r_id;
    logic [31:0] r_per;
    logic [31:0] r_last;
    t_tok        r_tok;

    logic [31:0] w_elapsed;
    logic        w_due;
    logic        w_reg_take;
    logic        w_act_hit;
    t_tok        n_tok;

    // per-entry decisions for the passing token
    always_comb begin
        w_elapsed  = i_tok.now - r_last;
        w_due      = i_tok.v && (i_tok.op == OP_TICK) && r_occ && r_ready
                     && (w_elapsed >= r_per);
        w_reg_take = i_tok.v && (i_tok.op == OP_REG) && !r_occ && !i_tok.flag;
        w_act_hit  = i_tok.v && (i_tok.op == OP_ACT) && r_occ && !i_tok.flag
                     && (r_id == i_tok.id);
        n_tok      = i_tok;
        n_tok.flag = i_tok.flag | w_reg_take | w_act_hit;
    end

    // entry state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ   <= 1'b0;
            r_ready <= 1'b0;
        end else if (i_adv) begin
            if (w_reg_take) begin
                r_occ   <= 1'b1;
                r_ready <= 1'b1;
            end else if (w_act_hit) begin
                r_ready <= 1'b1;
            end
        end
    end

    // entry payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            if (w_reg_take) begin
                r_id   <= i_tok.id;
                r_per  <= i_tok.per;
                r_last <= '0;
            end else if (w_due) begin
                r_last <= i_tok.now;
            end
        end
    end

    // token hand-off to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.v <= 1'b0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok    = r_tok;
    assign o_evt.v  = w_due;
    assign o_evt.id = w_due ? r_id : 8'd0;

endmodule

`default_nettype wire

FILE: rtl/core/periodic_task_dispatcher_top.sv
// channel | handshake                   | fields
// in      | i_in_valid / o_in_stall     | i_op, i_task_id, i_period
// out     | o_out_valid / i_out_stall   | o_status, o_dispatch_valid, o_dispatched_id,
//         |                             | o_tick_now, o_last
//
// one item at a time: a command token walks the row of MAX_TASKS cells, one cell
// per cycle while the output is not stalled
// a stalled output freezes the whole row until the result register drains
// each dispatch is held back so that the final result of a tick carries last
// reset clears occupancy, ready marks, the tick counter and all handshake state;
// entry payload needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module periodic_task_dispatcher_top #(
    parameter int MAX_TASKS = ptd_pkg::MAX_TASKS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_task_id,
    input  logic [31:0] i_period,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_status,
    output logic        o_dispatch_valid,
    output logic [7:0]  o_dispatched_id,
    output logic [31:0] o_tick_now,
    output logic        o_last
);
    import ptd_pkg::*;

    logic        r_busy;
    logic [31:0] r_tick;
    t_tok        r_launch;
    logic [1:0]  r_op;
    logic [31:0] r_now;
    logic        r_pv;
    logic [7:0]  r_pid;

    logic        r_ov;
    logic        r_status;
    logic        r_dv;
    logic [7:0]  r_did;
    logic [31:0] r_onow;
    logic        r_last;

    t_tok        w_link [MAX_TASKS+1];
    t_evt        w_cevt [MAX_TASKS];
    t_evt        w_evt;
    logic        w_acc;
    logic        w_adv;
    logic        w_end;
    t_tok        w_end_tok;
    logic [MAX_TASKS:0] w_tok_v;

    assign w_acc      = i_in_valid && !r_busy;
    assign w_adv      = !r_ov || !i_out_stall;
    assign o_in_stall = r_busy;

    // row of cells
    assign w_link[0] = r_launch;
    for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
        ptd_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_adv  (w_adv),
            .i_tok  (w_link[k]),
            .o_tok  (w_link[k+1]),
            .o_evt  (w_cevt[k])
        );
    end

    // only the cell holding the token can raise an event
    always_comb begin
        w_evt = '0;
        for (int k = 0; k < MAX_TASKS; k++) begin
            w_evt = w_evt | w_cevt[k];
        end
    end

    assign w_end_tok = w_link[MAX_TASKS];
    assign w_end     = w_end_tok.v;

    always_comb begin
        for (int k = 0; k <= MAX_TASKS; k++) begin
            w_tok_v[k] = w_link[k].v;
        end
    end

    // accept, launch and tick counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_tick     <= '0;
            r_launch.v <= 1'b0;
        end else begin
            if (w_acc) begin
                r_busy          <= 1'b1;
                r_launch.v      <= 1'b1;
                r_launch.op     <= i_op;
                r_launch.id     <= i_task_id;
                r_launch.per    <= i_period;
                r_launch.now    <= r_tick;
                r_launch.flag   <= 1'b0;
                if (i_op == OP_TICK) begin
                    r_tick <= r_tick + 32'd1;
                end
            end else if (w_adv) begin
                r_launch.v <= 1'b0;
            end
            if (w_adv && w_end) begin
                r_busy <= 1'b0;
            end
        end
    end

    // item context for result assembly
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_op  <= i_op;
            r_now <= r_tick;
        end
    end

    // held dispatch and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            // on an advance the result register is empty or draining
            if (w_adv) begin
                r_ov <= (w_evt.v && r_pv) || w_end;
            end
            if (w_adv && w_evt.v) begin
                r_pv  <= 1'b1;
                r_pid <= w_evt.id;
                if (r_pv) begin
                    r_status <= ST_OK;
                    r_dv     <= 1'b1;
                    r_did    <= r_pid;
                    r_onow   <= r_now;
                    r_last   <= 1'b0;
                end
            end else if (w_adv && w_end) begin
                r_pv   <= 1'b0;
                r_onow <= r_now;
                r_last <= 1'b1;
                unique case (r_op) inside
                    OP_REG, OP_ACT: begin
                        r_status <= w_end_tok.flag ? ST_OK : ST_ERR;
                        r_dv     <= 1'b0;
                        r_did    <= 8'd0;
                    end
                    OP_TICK: begin
                        r_status <= ST_OK;
                        r_dv     <= r_pv;
                        r_did    <= r_pv ? r_pid : 8'd0;
                    end
                    default: begin
                        r_status <= ST_ERR;
                        r_dv     <= 1'b0;
                        r_did    <= 8'd0;
                    end
                endcase
            end
        end
    end

    assign o_out_valid      = r_ov;
    assign o_status         = r_status;
    assign o_dispatch_valid = r_dv;
    assign o_dispatched_id  = r_did;
    assign o_tick_now       = r_onow;
    assign o_last           = r_last;

    // at most one token in the row
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_tok_v))
        else $error("more than one token in the cell row");

    // a launched or finished token is only present while an item is in progress
    a_tok_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_end || r_launch.v) |-> r_busy)
        else $error("token seen while idle");

    // a held dispatch only exists during a tick
    a_pend_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_busy && r_op == OP_TICK))
        else $error("held dispatch outside a tick");

    // an accepted item starts its walk at the head of the row
    a_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_busy && r_launch.v))
        else $error("accepted item not launched");

endmodule

`default_nettype wire
